### hw/rtl/reversible_deque_top_assert.svh
// Assertion macros shared by the reversible deque RTL.
`ifndef REVERSIBLE_DEQUE_TOP_ASSERT_SVH
`define REVERSIBLE_DEQUE_TOP_ASSERT_SVH
`ifndef SYNTH
// Checked property, disabled while reset is held.
`define RD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("reversible deque check failed");
// Checked property that stays live through reset.
`define RD_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("reversible deque reset check failed");
`else
`define RD_ASSERT(lbl, clk, rstn, prop)
`define RD_ASSERT_RST(lbl, clk, prop)
`endif
`endif

### hw/rtl/rd_pkg.sv
// Package with the sizes, codes and types of the reversible deque.
package rd_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int OP_W       = 3;
    localparam int COUNT_W    = $clog2(DEPTH + 1);
    localparam int ERR_W      = 2;

    // Operation codes carried by an input transaction.
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_REVERSE    = 3'd4
    } t_op;

    // Error codes reported with every result.
    typedef enum logic [ERR_W-1:0] {
        ERR_NONE      = 2'd0,
        ERR_POP_EMPTY = 2'd1,
        ERR_PUSH_FULL = 2'd2
    } t_err;

    // Command broadcast to every cell of the row.
    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_SHIFT_UP,
        CMD_SHIFT_DOWN,
        CMD_APPEND,
        CMD_DROP_LAST
    } t_cell_cmd;

    typedef logic [DATA_WIDTH-1:0] t_word;

    // Control bundle from the sequencer to the cells.
    typedef struct packed {
        t_cell_cmd cmd;
        t_word     push_data;
    } t_cell_ctl;

endpackage

### hw/rtl/rd_if.sv
// Valid/ready channel interfaces for the input and result transactions.
interface rd_in_if
    import rd_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [OP_W-1:0]       op;
    logic signed [DATA_WIDTH-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface rd_out_if
    import rd_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic signed [DATA_WIDTH-1:0] front_value;
    logic signed [DATA_WIDTH-1:0] back_value;
    logic [COUNT_W-1:0]    count;
    logic                  is_empty;
    logic [ERR_W-1:0]      error;

    modport source (output valid, output front_value, output back_value, output count,
                    output is_empty, output error, input ready);
    modport sink   (input valid, input front_value, input back_value, input count,
                    input is_empty, input error, output ready);
endinterface

### hw/rtl/rd_cell.sv
// One storage cell of the deque row, exchanging its word with its neighbors.
module rd_cell
    import rd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_word     i_lower_data,
    input  logic      i_lower_valid,
    input  t_word     i_upper_data,
    input  logic      i_upper_valid,
    output t_word     o_data,
    output logic      o_valid,
    output logic      o_is_last
);

    t_word r_data;
    t_word n_data;
    logic  r_valid;
    logic  n_valid;

    // Next word and occupancy for the broadcast command.
    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        unique case (i_ctl.cmd)
            CMD_SHIFT_UP: begin
                n_data  = i_lower_data;
                n_valid = i_lower_valid;
            end
            CMD_SHIFT_DOWN: begin
                n_data  = i_upper_data;
                n_valid = i_upper_valid;
            end
            CMD_APPEND: begin
                // The first free cell above the occupied run takes the word.
                if (i_lower_valid && !r_valid) begin
                    n_data  = i_ctl.push_data;
                    n_valid = 1'b1;
                end
            end
            CMD_DROP_LAST: begin
                if (r_valid && !i_upper_valid) begin
                    n_valid = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // Occupancy flag is control state; the word itself needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data    = r_data;
    assign o_valid   = r_valid;
    assign o_is_last = r_valid && !i_upper_valid;

endmodule

### hw/rtl/reversible_deque_top.sv
// Top level of the reversible deque: operation sequencer over a row of cells.
//
//  Channel   Direction  Contents
//  i_in      sink       op, value
//  o_out     source     front_value, back_value, count, is_empty, error
//
// One operation per cycle unless the result is stalled; each result is registered
// and appears in the cycle after its transaction. The cell row shifts by one
// place per operation, so no operation takes longer at a higher fill level.
// Reset clears the occupancy of every cell, the count and the reverse flag.
// A new transaction is taken while the result register is empty or is being
// drained in the same cycle; a stalled result holds the cell row unchanged.
`include "reversible_deque_top_assert.svh"
module reversible_deque_top
    import rd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    rd_in_if.sink    i_in,
    rd_out_if.source o_out
);

    logic               w_accept;
    logic               w_full;
    logic               w_empty;
    t_cell_cmd          w_cmd;
    t_cell_ctl          w_ctl;
    t_err               n_err;
    logic               n_rev;
    logic [COUNT_W-1:0] n_count;

    logic               r_rev;
    logic [COUNT_W-1:0] r_count;
    logic               r_out_valid;
    t_err               r_err;

    t_word              w_data [DEPTH];
    logic [DEPTH-1:0]   w_valid;
    logic [DEPTH-1:0]   w_is_last;
    t_word              w_last_word;
    t_word              w_first_word;

    // Handshake: take a transaction whenever the result register is free or being drained.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_full     = (r_count == COUNT_W'(DEPTH));
    assign w_empty    = (r_count == '0);

    // Map the logical operation onto a physical cell command.
    always_comb begin
        w_cmd   = CMD_HOLD;
        n_err   = ERR_NONE;
        n_rev   = r_rev;
        n_count = r_count;
        unique case (i_in.op)
            OP_PUSH_FRONT: begin
                if (w_full) begin
                    n_err = ERR_PUSH_FULL;
                end else begin
                    w_cmd   = r_rev ? CMD_APPEND : CMD_SHIFT_UP;
                    n_count = r_count + 1'b1;
                end
            end
            OP_PUSH_BACK: begin
                if (w_full) begin
                    n_err = ERR_PUSH_FULL;
                end else begin
                    w_cmd   = r_rev ? CMD_SHIFT_UP : CMD_APPEND;
                    n_count = r_count + 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (w_empty) begin
                    n_err = ERR_POP_EMPTY;
                end else begin
                    w_cmd   = r_rev ? CMD_DROP_LAST : CMD_SHIFT_DOWN;
                    n_count = r_count - 1'b1;
                end
            end
            OP_POP_BACK: begin
                if (w_empty) begin
                    n_err = ERR_POP_EMPTY;
                end else begin
                    w_cmd   = r_rev ? CMD_SHIFT_DOWN : CMD_DROP_LAST;
                    n_count = r_count - 1'b1;
                end
            end
            OP_REVERSE: begin
                n_rev = !r_rev;
            end
            default: begin
            end
        endcase
    end

    assign w_ctl.cmd       = w_accept ? w_cmd : CMD_HOLD;
    assign w_ctl.push_data = t_word'(i_in.value);

    // Sequencer state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rev       <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_err       <= ERR_NONE;
        end else begin
            if (w_accept) begin
                r_rev       <= n_rev;
                r_count     <= n_count;
                r_err       <= n_err;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Row of cells; cell 0 is the physical first end.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        t_word w_lower_data;
        logic  w_lower_valid;
        t_word w_upper_data;
        logic  w_upper_valid;

        if (i == 0) begin : g_first
            assign w_lower_data  = t_word'(i_in.value);
            assign w_lower_valid = 1'b1;
        end else begin : g_mid_lo
            assign w_lower_data  = w_data[i-1];
            assign w_lower_valid = w_valid[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign w_upper_data  = '0;
            assign w_upper_valid = 1'b0;
        end else begin : g_mid_hi
            assign w_upper_data  = w_data[i+1];
            assign w_upper_valid = w_valid[i+1];
        end

        rd_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_lower_data  (w_lower_data),
            .i_lower_valid (w_lower_valid),
            .i_upper_data  (w_upper_data),
            .i_upper_valid (w_upper_valid),
            .o_data        (w_data[i]),
            .o_valid       (w_valid[i]),
            .o_is_last     (w_is_last[i])
        );
    end

    // Pick the word of the one cell that ends the occupied run.
    always_comb begin
        w_last_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_last_word = w_last_word | (w_data[i] & {DATA_WIDTH{w_is_last[i]}});
        end
    end

    assign w_first_word = w_valid[0] ? w_data[0] : '0;

    // Result fields are read from the row, which holds still while stalled.
    assign o_out.valid       = r_out_valid;
    assign o_out.front_value = r_rev ? w_last_word : w_first_word;
    assign o_out.back_value  = r_rev ? w_first_word : w_last_word;
    assign o_out.count       = r_count;
    assign o_out.is_empty    = w_empty;
    assign o_out.error       = r_err;

    // The count tracks the number of occupied cells.
    `RD_ASSERT(a_count_matches_row, i_clk, i_rst_n, r_count == COUNT_W'($countones(w_valid)))
    // The occupied run has at most one end.
    `RD_ASSERT(a_single_last, i_clk, i_rst_n, $onehot0(w_is_last))
    // A dropped push is only reported on a full deque.
    `RD_ASSERT(a_full_error, i_clk, i_rst_n,
        (r_out_valid && r_err == ERR_PUSH_FULL) |-> w_full)
    // No result is pending right after reset.
    `RD_ASSERT_RST(a_reset_clears_out, i_clk, !i_rst_n |=> !r_out_valid)

endmodule
